@@ src/ffpa_pkg.sv @@
`timescale 1ns / 1ps
package ffpa_pkg;
   localparam logic [1:0] ST_OK         = 2'd0;
   localparam logic [1:0] ST_POOL_FULL  = 2'd1;
   localparam logic [1:0] ST_TABLE_FULL = 2'd2;
   localparam logic [1:0] ST_BAD_FREE   = 2'd3;
   localparam logic       CMD_ALLOC     = 1'b0;
   localparam logic       CMD_FREE      = 1'b1;
   localparam logic       CSR_POOL_BYTES = 1'b0;
   localparam logic       CSR_ALIGN_LOG2 = 1'b1;
   localparam logic [3:0] ALIGN_LOG2_MAX = 4'd12;
   localparam logic [3:0] ALIGN_LOG2_RST = 4'd4;
endpackage

@@ src/ffpa_ram.sv @@
`timescale 1ns / 1ps
module ffpa_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   // one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

@@ src/first_fit_pool_allocator.sv @@
`timescale 1ns / 1ps
// channel | direction | contents
// req     | in        | tdata: cmd[0], req_size[32:1], free_offset[64:33], zero pad to 72
// rsp     | out       | tdata: region_offset[31:0], status[33:32], regions_live[40:34], pad to 48
// csr     | in        | write enable, index (0 pool_bytes, 1 align_log2), 32 bit data
// An allocate scans the sorted table for a gap, then moves entries up one place
// from the top, through a read state and a write state for each entry moved.
// A free searches for the offset, then moves the entries above the match down,
// again through a read state and a write state for each entry.
// The table RAM does one read and one write per cycle, so each move reads, then writes.
// Reset is synchronous: it clears only the region count and control and restores the CSR
// defaults; entries past the count go unused. A stalled result holds; a new request waits.
module first_fit_pool_allocator #(
   parameter int MAX_REGIONS = 64,
   parameter int OFFSET_BITS = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [71:0] req_tdata,  // cmd, req_size, free_offset
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,  // region_offset, status, regions_live
   input  logic        csr_wr_en,
   input  logic        csr_index,
   input  logic [31:0] csr_wr_data
);
   localparam int AW = $clog2(MAX_REGIONS);
   localparam int CW = $clog2(MAX_REGIONS + 1);
   localparam int VW = ((OFFSET_BITS > 32) ? OFFSET_BITS : 32) + 2;

   typedef enum logic [2:0] {
      S_IDLE, S_SCAN, S_MOVE_RD, S_MOVE_WR, S_DONE
   } state_type;

   state_type        state_ff, state_in;
   logic [31:0]      pool_ff;
   logic [3:0]       align_ff;
   logic [CW-1:0]    count_ff, count_in;
   logic             cmd_ff, cmd_in;
   logic [VW-1:0]    size_ff, size_in, foff_ff, foff_in;
   logic [VW-1:0]    prev_end_ff, prev_end_in, base_ff, base_in;
   logic [CW-1:0]    idx_ff, idx_in, pos_ff, pos_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [31:0]      rsp_off_ff, rsp_off_in;
   logic [1:0]       rsp_st_ff, rsp_st_in;
   logic [CW-1:0]    rsp_live_ff, rsp_live_in;

   logic             wr_en;
   logic [AW-1:0]    wr_addr, rd_addr;
   logic [2*VW-1:0]  wr_data, rd_data;
   logic [VW-1:0]    ent_start, ent_len, lim, rnd, mask, cand;
   logic [3:0]       align_eff;

   ffpa_ram #(.WIDTH(2 * VW), .DEPTH(MAX_REGIONS)) u_table (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_data),
      .rd_addr(rd_addr),
      .rd_data(rd_data)
   );

   assign ent_start = rd_data[VW-1:0];
   assign ent_len   = rd_data[2*VW-1:VW];
   assign align_eff = (align_ff > ffpa_pkg::ALIGN_LOG2_MAX) ? ffpa_pkg::ALIGN_LOG2_MAX
                                                             : align_ff;
   assign mask      = (VW'(1) << align_eff) - VW'(1);
   // usable limit: pool size capped at 2^OFFSET_BITS
   always_comb begin
      if (VW'(pool_ff) > (VW'(1) << OFFSET_BITS)) lim = VW'(1) << OFFSET_BITS;
      else lim = VW'(pool_ff);
   end
   assign rnd  = (prev_end_ff + mask) & ~mask;
   assign cand = ent_start + ent_len;

   assign req_tready = (state_ff == S_IDLE) && !rsp_valid_ff;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'd0, 7'(rsp_live_ff), rsp_st_ff, rsp_off_ff};

   // sequencer
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      cmd_in       = cmd_ff;
      size_in      = size_ff;
      foff_in      = foff_ff;
      prev_end_in  = prev_end_ff;
      base_in      = base_ff;
      idx_in       = idx_ff;
      pos_in       = pos_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_off_in   = rsp_off_ff;
      rsp_st_in    = rsp_st_ff;
      rsp_live_in  = rsp_live_ff;
      wr_en        = 1'b0;
      wr_addr      = idx_ff[AW-1:0];
      wr_data      = rd_data;
      rd_addr      = idx_ff[AW-1:0];
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid && req_tready) begin
               cmd_in      = req_tdata[0];
               size_in     = (req_tdata[32:1] == 32'd0) ? VW'(1) : VW'(req_tdata[32:1]);
               foff_in     = VW'(req_tdata[64:33]);
               prev_end_in = '0;
               idx_in      = '0;
               rd_addr     = '0;
               rsp_off_in  = '0;
               rsp_live_in = count_ff;
               if (req_tdata[0] == ffpa_pkg::CMD_FREE) begin
                  if (VW'(req_tdata[64:33]) >= lim || count_ff == '0) begin
                     rsp_st_in = ffpa_pkg::ST_BAD_FREE;
                     state_in  = S_DONE;
                  end else begin
                     state_in = S_SCAN;
                  end
               end else if (count_ff >= CW'(MAX_REGIONS)) begin
                  rsp_st_in = ffpa_pkg::ST_TABLE_FULL;
                  state_in  = S_DONE;
               end else begin
                  state_in = S_SCAN;
               end
            end
         end
         S_SCAN: begin
            // rd_data holds entry idx_ff, or past end when idx_ff == count
            if (cmd_ff == ffpa_pkg::CMD_FREE) begin
               if (idx_ff == count_ff) begin
                  rsp_st_in = ffpa_pkg::ST_BAD_FREE;
                  state_in  = S_DONE;
               end else if (ent_start == foff_ff) begin
                  // close the hole: copy entry i+1 into i
                  pos_in   = idx_ff;
                  state_in = S_MOVE_RD;
                  rd_addr  = AW'(idx_ff + CW'(1));
                  idx_in   = idx_ff + CW'(1);
               end else begin
                  idx_in  = idx_ff + CW'(1);
                  rd_addr = AW'(idx_ff + CW'(1));
               end
            end else begin
               if (idx_ff == count_ff) begin
                  if (rnd > lim || lim - rnd < size_ff) begin
                     rsp_st_in = ffpa_pkg::ST_POOL_FULL;
                     state_in  = S_DONE;
                  end else begin
                     base_in  = rnd;
                     pos_in   = idx_ff;
                     idx_in   = count_ff;
                     rd_addr  = AW'(count_ff - CW'(1));
                     state_in = S_MOVE_RD;
                  end
               end else if (rnd <= ent_start && ent_start - rnd >= size_ff) begin
                  base_in  = rnd;
                  pos_in   = idx_ff;
                  idx_in   = count_ff;
                  rd_addr  = AW'(count_ff - CW'(1));
                  state_in = S_MOVE_RD;
               end else begin
                  prev_end_in = cand;
                  idx_in      = idx_ff + CW'(1);
                  rd_addr     = AW'(idx_ff + CW'(1));
               end
            end
         end
         S_MOVE_RD: begin
            // alloc: idx is destination, reads idx-1; free: idx is source
            if (cmd_ff == ffpa_pkg::CMD_FREE) begin
               rd_addr = idx_ff[AW-1:0];
               if (idx_ff >= count_ff) begin
                  count_in    = count_ff - CW'(1);
                  rsp_live_in = count_ff - CW'(1);
                  rsp_st_in   = ffpa_pkg::ST_OK;
                  state_in    = S_DONE;
               end else begin
                  state_in = S_MOVE_WR;
               end
            end else begin
               rd_addr = AW'(idx_ff - CW'(1));
               if (idx_ff == pos_ff) begin
                  wr_en       = 1'b1;
                  wr_addr     = pos_ff[AW-1:0];
                  wr_data     = {size_ff, base_ff};
                  count_in    = count_ff + CW'(1);
                  rsp_live_in = count_ff + CW'(1);
                  rsp_off_in  = 32'(base_ff);
                  rsp_st_in   = ffpa_pkg::ST_OK;
                  state_in    = S_DONE;
               end else begin
                  state_in = S_MOVE_WR;
               end
            end
         end
         S_MOVE_WR: begin
            wr_en = 1'b1;
            if (cmd_ff == ffpa_pkg::CMD_FREE) begin
               wr_addr = AW'(idx_ff - CW'(1));
               idx_in  = idx_ff + CW'(1);
               rd_addr = AW'(idx_ff + CW'(1));
            end else begin
               wr_addr = idx_ff[AW-1:0];
               idx_in  = idx_ff - CW'(1);
               rd_addr = AW'(idx_ff - CW'(2));
            end
            state_in = S_MOVE_RD;
         end
         S_DONE: begin
            rsp_valid_in = 1'b1;
            state_in     = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // state, configuration and response registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         pool_ff      <= 32'hFFFF_FFFF;
         align_ff     <= ffpa_pkg::ALIGN_LOG2_RST;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en && csr_index == ffpa_pkg::CSR_POOL_BYTES) pool_ff <= csr_wr_data;
         if (csr_wr_en && csr_index == ffpa_pkg::CSR_ALIGN_LOG2) align_ff <= csr_wr_data[3:0];
      end
      cmd_ff      <= cmd_in;
      size_ff     <= size_in;
      foff_ff     <= foff_in;
      prev_end_ff <= prev_end_in;
      base_ff     <= base_in;
      idx_ff      <= idx_in;
      pos_ff      <= pos_in;
      rsp_off_ff  <= rsp_off_in;
      rsp_st_ff   <= rsp_st_in;
      rsp_live_ff <= rsp_live_in;
   end
endmodule
